// ----- design/fifo_reuse_handle_pool_top_assert.svh -----
// ----------------------------------------------------------------------------
// handle pool assertion macros
// shared property forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef FIFO_REUSE_HANDLE_POOL_TOP_ASSERT_SVH
`define FIFO_REUSE_HANDLE_POOL_TOP_ASSERT_SVH

// same-cycle implication
`define FRHP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("handle pool assertion failed");

// next-cycle implication
`define FRHP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("handle pool assertion failed");

`endif

// ----- design/frhp_pkg.sv -----
// ----------------------------------------------------------------------------
// frhp_pkg
// shared types and constants of the handle pool
// ----------------------------------------------------------------------------
package frhp_pkg;

	localparam int POOL_SIZE = 64;
	localparam int PTR_W     = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);
	localparam int HANDLE_W  = 6;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_TRY   = 2'd1,
		ACT_FREE  = 2'd2
	} act_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_NONE    = 2'd1,
		ST_INVALID = 2'd2
	} status_e_t;

	typedef enum logic {
		STATE_IDLE,
		STATE_EXEC
	} state_t;

	typedef struct packed {
		logic [ACT_W-1:0]    action;
		logic [HANDLE_W-1:0] release_handle;
	} req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] granted_handle;
		logic [STAT_W-1:0]   status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic fifo_empty;
		logic pool_drained;
	} sts_t;

endpackage

// ----- design/frhp_dp.sv -----
// ----------------------------------------------------------------------------
// frhp_dp
// request latch, free handle fifo, in-use bitmap and response register
// ----------------------------------------------------------------------------
module frhp_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  frhp_pkg::cmd_t cmd,
	output frhp_pkg::sts_t sts,
	input  frhp_pkg::req_t req,
	output frhp_pkg::rsp_t rsp
);
	import frhp_pkg::*;

	logic [ACT_W-1:0]    act_q;
	logic [HANDLE_W-1:0] rel_q;
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    fresh_q;
	logic [POOL_SIZE-1:0] in_use_q;
	logic [PTR_W-1:0]    mem [POOL_SIZE];
	logic [PTR_W-1:0]    rd_data_q;
	logic [HANDLE_W-1:0] granted_q;
	logic [STAT_W-1:0]   status_q;

	logic                pop;
	logic                take_fresh;
	logic                push;
	logic                rel_ok;
	logic [PTR_W-1:0]    rel_idx;
	logic [PTR_W-1:0]    grant_idx;
	logic [HANDLE_W-1:0] granted_d;
	logic [STAT_W-1:0]   status_d;

	assign rel_idx = PTR_W'(rel_q);
	assign rel_ok  = (CNT_W'(rel_q) < CNT_W'(POOL_SIZE)) && in_use_q[rel_idx]
		&& (count_q < CNT_W'(POOL_SIZE));

	always_comb begin
		pop        = 1'b0;
		take_fresh = 1'b0;
		push       = 1'b0;
		grant_idx  = rd_data_q;
		granted_d  = '0;
		status_d   = ST_OK;
		unique case (act_q)
			ACT_ALLOC, ACT_TRY: begin
				if (count_q != '0) begin
					pop       = 1'b1;
					grant_idx = rd_data_q;
					granted_d = HANDLE_W'(rd_data_q);
				end else if (act_q == ACT_ALLOC && fresh_q < CNT_W'(POOL_SIZE)) begin
					take_fresh = 1'b1;
					grant_idx  = PTR_W'(fresh_q);
					granted_d  = HANDLE_W'(fresh_q);
				end else begin
					status_d = ST_NONE;
				end
			end
			ACT_FREE: begin
				if (rel_ok) begin
					push = 1'b1;
				end else begin
					status_d = ST_INVALID;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= req.action;
			rel_q <= req.release_handle;
		end
		if (cmd.exec) begin
			granted_q <= granted_d;
			status_q  <= status_d;
		end
		if (cmd.exec && push) begin
			mem[tail_q] <= rel_idx;
		end
		rd_data_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			fresh_q  <= '0;
			in_use_q <= '0;
		end else if (cmd.exec) begin
			if (pop) begin
				head_q  <= (head_q == PTR_W'(POOL_SIZE - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (push) begin
				tail_q            <= (tail_q == PTR_W'(POOL_SIZE - 1)) ? '0 : tail_q + 1'b1;
				count_q           <= count_q + 1'b1;
				in_use_q[rel_idx] <= 1'b0;
			end
			if (take_fresh) begin
				fresh_q <= fresh_q + 1'b1;
			end
			if (pop || take_fresh) begin
				in_use_q[grant_idx] <= 1'b1;
			end
		end
	end

	assign rsp.granted_handle = granted_q;
	assign rsp.status         = status_q;
	assign sts.fifo_empty     = (count_q == '0);
	assign sts.pool_drained   = (fresh_q == CNT_W'(POOL_SIZE));

`include "fifo_reuse_handle_pool_top_assert.svh"

	`FRHP_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(POOL_SIZE))
	`FRHP_ASSERT_IMPL(a_count_fresh, 1'b1, count_q <= fresh_q)
	`FRHP_ASSERT_IMPL(a_empty_ptrs, count_q == '0, head_q == tail_q)

endmodule

// ----- design/frhp_ctrl.sv -----
// ----------------------------------------------------------------------------
// frhp_ctrl
// request sequencing and response valid tracking
// ----------------------------------------------------------------------------
module frhp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output frhp_pkg::cmd_t cmd,
	input  frhp_pkg::sts_t sts
);
	import frhp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			STATE_IDLE: begin
				if (req_valid && req_ready) begin
					state_d = STATE_EXEC;
				end
			end
			STATE_EXEC: begin
				state_d = STATE_IDLE;
			end
			default: begin
				state_d = STATE_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			STATE_IDLE: begin
				req_ready = !rsp_valid_q || rsp_ready;
				cmd.load  = req_valid && req_ready;
			end
			STATE_EXEC: begin
				cmd.exec = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

`include "fifo_reuse_handle_pool_top_assert.svh"

	`FRHP_ASSERT_NEXT(a_load_exec, cmd.load, cmd.exec)
	`FRHP_ASSERT_NEXT(a_exec_rsp, cmd.exec, rsp_valid)
	`FRHP_ASSERT_IMPL(a_exec_block, cmd.exec, !req_ready)
	`FRHP_ASSERT_NEXT(a_drain_hold, !cmd.exec && !sts.pool_drained, !sts.pool_drained)
	`FRHP_ASSERT_NEXT(a_empty_hold, !cmd.exec, sts.fifo_empty == $past(sts.fifo_empty))

endmodule

// ----- design/fifo_reuse_handle_pool_top.sv -----
// ----------------------------------------------------------------------------
// fifo_reuse_handle_pool_top: handle pool with fifo reuse of freed handles
// response: rsp_valid is registered at the end of the execute state after the load
// pacing: load and execute states around the registered fifo read; the next
// request waits for the idle state and for rsp_ready or no pending response
// reset: bitmap, fifo pointers and fresh counter clear at once, no sweep
// ----------------------------------------------------------------------------
module fifo_reuse_handle_pool_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  frhp_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output frhp_pkg::rsp_t rsp
);
	import frhp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	frhp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	frhp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
